FILE: rtl/utf_desc_pkg.sv
// Package for the UTF-8 to UTF-16 descriptor fill block.
// Holds result codes, the result queue entry type and the count helper.
// No dependencies.
`default_nettype none

package utf_desc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned POINT_W = 32;
    localparam int unsigned PEND_W  = 3;

    // result kinds
    localparam logic KIND_UNIT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [WORD_W-1:0]  LIMIT_RESET  = 16'd255;
    localparam logic [WORD_W-1:0]  COUNT_RESET  = 16'd2;
    localparam logic [11:0]        LEAD_MASK    = 12'h0f80;
    localparam logic [POINT_W-1:0] PLANE1_BASE  = 32'h0001_0000;
    localparam logic [WORD_W-1:0]  HIGH_SURR    = 16'hd800;
    localparam logic [WORD_W-1:0]  LOW_SURR     = 16'hdc00;

    // result queue
    localparam int unsigned QDEPTH = 3;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 2;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] val_a;   // code unit, or descriptor length
        logic [WORD_W-1:0] val_b;   // unit offset, or response length
    } res_entry_t;

    // byte count step: +2, saturating at 0xffff
    function automatic logic [WORD_W-1:0] count_step(input logic [WORD_W-1:0] c);
        logic [WORD_W:0] sum;
        sum = {1'b0, c} + 17'd2;
        count_step = sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
    endfunction

    // queue pointer advance modulo QDEPTH, step of 0..2
    function automatic logic [QPTR_W-1:0] ptr_adv(input logic [QPTR_W-1:0] p,
                                                  input logic [1:0] k);
        logic [QPTR_W:0] sum;
        sum = {1'b0, p} + {1'b0, k};
        if (sum >= (QPTR_W+1)'(QDEPTH))
            sum = sum - (QPTR_W+1)'(QDEPTH);
        ptr_adv = sum[QPTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8_to_utf16_descriptor_fill_top.sv
// UTF-8 to UTF-16 USB string descriptor fill, top level. Uses utf_desc_pkg.
// Results are registered into the result queue on the input byte transfer.
// Throughput: one byte per cycle; a surrogate pair puts up to two results in
// the three-entry result queue, drained one per cycle while m_ready is high;
// input stalls only while the queue is full, or holds two and m_ready is low.
// Reset (aresetn, synchronous, low): limit 255, byte count 2, no partial
// code point, result queue empty.
`default_nettype none

module utf8_to_utf16_descriptor_fill_top
    import utf_desc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration: response limit
    input  wire logic              cfg_wr_en,
    input  wire logic [WORD_W-1:0] cfg_wr_data,
    // input byte channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_text_byte,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_kind,
    output logic [WORD_W-1:0]      m_code_unit,
    output logic [WORD_W-1:0]      m_unit_offset,
    output logic [WORD_W-1:0]      m_descriptor_length,
    output logic [WORD_W-1:0]      m_response_length,
    output logic                   m_last
);

    // decoder state
    logic [WORD_W-1:0]  limit_reg;
    logic [POINT_W-1:0] point_reg, point_next;
    logic [PEND_W-1:0]  pend_reg,  pend_next;
    logic [WORD_W-1:0]  count_reg, count_next;

    // result queue
    res_entry_t         q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  q_cnt_reg;

    logic in_xfer, out_xfer;

    // lead byte decode
    logic               lead_ascii;
    logic [PEND_W-1:0]  lead_ext;
    logic [11:0]        lead_mask;
    logic [BYTE_W-1:0]  lead_cp;

    // code point emission
    logic               emit_req;
    logic [POINT_W-1:0] emit_cp;
    logic               summ;
    logic [POINT_W-1:0] shifted;
    logic               single;
    logic [25:0]        v_off;
    logic [WORD_W-1:0]  unit0, unit1;
    logic [WORD_W-1:0]  cnt1, cnt2;
    logic               fit0, fit1;
    logic [WORD_W-1:0]  resp_len;

    logic [1:0]         push_n;
    res_entry_t         ent0, ent1;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    // room for a full surrogate pair, counting a pop in the same cycle
    assign s_ready = (q_cnt_reg <= QCNT_W'(1))
                     || (q_cnt_reg == QCNT_W'(2) && m_ready);
    assign m_valid = (q_cnt_reg != '0);

    // Leading-ones count of the lead byte. A stray continuation byte has no
    // extensions; 0xFF counts seven.
    always_comb begin
        lead_ascii = 1'b0;
        lead_ext   = '0;
        unique casez (s_text_byte)
            8'b0???????: lead_ascii = 1'b1;
            8'b10??????: lead_ext   = 3'd0;
            8'b110?????: lead_ext   = 3'd1;
            8'b1110????: lead_ext   = 3'd2;
            8'b11110???: lead_ext   = 3'd3;
            8'b111110??: lead_ext   = 3'd4;
            8'b1111110?: lead_ext   = 3'd5;
            8'b11111110: lead_ext   = 3'd6;
            8'b11111111: lead_ext   = 3'd7;
            default:     lead_ascii = 1'b1;
        endcase
    end

    assign lead_mask = LEAD_MASK >> lead_ext;
    assign lead_cp   = s_text_byte & ~lead_mask[BYTE_W-1:0];
    // continuation: shift in six payload bits, wrapping at 32 bits
    assign shifted   = {point_reg[POINT_W-7:0], s_text_byte[5:0]};

    // next decoder state and emission request
    always_comb begin
        point_next = point_reg;
        pend_next  = pend_reg;
        emit_req   = 1'b0;
        emit_cp    = '0;
        summ       = 1'b0;
        if (pend_reg != '0) begin
            // a zero byte here is payload, not end of string
            point_next = shifted;
            pend_next  = pend_reg - PEND_W'(1);
            if (pend_reg == PEND_W'(1)) begin
                emit_req = 1'b1;
                emit_cp  = shifted;
            end
        end else if (s_text_byte == '0) begin
            summ       = 1'b1;
            point_next = '0;
            pend_next  = '0;
        end else if (lead_ascii) begin
            emit_req = 1'b1;
            emit_cp  = {{(POINT_W-BYTE_W){1'b0}}, s_text_byte};
        end else if (lead_ext == '0) begin
            emit_req = 1'b1;
            emit_cp  = {{(POINT_W-BYTE_W){1'b0}}, lead_cp};
        end else begin
            point_next = {{(POINT_W-BYTE_W){1'b0}}, lead_cp};
            pend_next  = lead_ext;
        end
    end

    // UTF-16 units; only the low 26 bits of the offset point reach a unit
    assign single = (emit_cp[POINT_W-1:WORD_W] == '0);
    assign v_off  = emit_cp[25:0] - PLANE1_BASE[25:0];
    assign unit0  = single ? emit_cp[WORD_W-1:0] : (v_off[25:10] + HIGH_SURR);
    assign unit1  = {6'b0, v_off[9:0]} + LOW_SURR;

    // each unit fits if count + 1 < limit; the count grows either way
    assign cnt1 = count_step(count_reg);
    assign cnt2 = count_step(cnt1);
    assign fit0 = ({1'b0, count_reg} + 17'd1) < {1'b0, limit_reg};
    assign fit1 = ({1'b0, cnt1} + 17'd1) < {1'b0, limit_reg};

    assign resp_len = (count_reg < limit_reg) ? count_reg : limit_reg;

    // results of this byte, packed to the front
    always_comb begin
        push_n     = 2'd0;
        ent0       = '{kind: KIND_UNIT, val_a: unit0, val_b: count_reg};
        ent1       = '{kind: KIND_UNIT, val_a: unit1, val_b: cnt1};
        count_next = count_reg;
        if (summ) begin
            push_n     = 2'd1;
            ent0       = '{kind: KIND_SUMMARY, val_a: count_reg, val_b: resp_len};
            count_next = COUNT_RESET;
        end else if (emit_req) begin
            count_next = single ? cnt1 : cnt2;
            if (single) begin
                push_n = {1'b0, fit0};
            end else begin
                push_n = 2'(fit0) + 2'(fit1);
                if (!fit0)
                    ent0 = ent1;
            end
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg <= '0;
            pend_reg  <= '0;
            count_reg <= COUNT_RESET;
        end else if (in_xfer) begin
            point_reg <= point_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

    // queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            if (in_xfer)
                wr_ptr_reg <= ptr_adv(wr_ptr_reg, push_n);
            if (out_xfer)
                rd_ptr_reg <= ptr_adv(rd_ptr_reg, 2'd1);
            q_cnt_reg <= q_cnt_reg + (in_xfer ? push_n : 2'd0)
                         - QCNT_W'(out_xfer);
        end
    end

    // queue payload, no reset
    always_ff @(posedge aclk) begin
        if (in_xfer && push_n != 2'd0)
            q_mem[wr_ptr_reg] <= ent0;
        if (in_xfer && push_n == 2'd2)
            q_mem[ptr_adv(wr_ptr_reg, 2'd1)] <= ent1;
    end

    // fields not meaningful for a kind read as zero
    always_comb begin
        m_kind              = q_mem[rd_ptr_reg].kind;
        m_last              = (m_kind == KIND_SUMMARY);
        m_code_unit         = '0;
        m_unit_offset       = '0;
        m_descriptor_length = '0;
        m_response_length   = '0;
        if (m_kind == KIND_SUMMARY) begin
            m_descriptor_length = q_mem[rd_ptr_reg].val_a;
            m_response_length   = q_mem[rd_ptr_reg].val_b;
        end else begin
            m_code_unit   = q_mem[rd_ptr_reg].val_a;
            m_unit_offset = q_mem[rd_ptr_reg].val_b;
        end
    end

`ifndef SYNTHESIS
    // count never drops below the header size
    a_count_min: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= COUNT_RESET)
        else $error("byte count below header size");

    // end of string restarts the count
    a_summary_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && pend_reg == '0 && s_text_byte == '0) |=> count_reg == COUNT_RESET)
        else $error("count not restarted after end of string");

    // a continuation byte that does not finish a sequence pushes nothing
    a_mid_seq_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && pend_reg > PEND_W'(1)) |-> push_n == 2'd0)
        else $error("result pushed mid sequence");

    // a pop with no input transfer shrinks the queue by one
    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xfer && !in_xfer) |=> q_cnt_reg == $past(q_cnt_reg) - QCNT_W'(1))
        else $error("queue count wrong after pop");
`endif

endmodule

`default_nettype wire
